>>> hw/rtl/circular_doubly_linked_list_assert.svh
// ----------------------------------------------------------------------------
// circular_doubly_linked_list assertion macros
// Shorthand for clocked properties on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DOUBLY_LINKED_LIST_ASSERT_SVH
`define CIRCULAR_DOUBLY_LINKED_LIST_ASSERT_SVH

// same-cycle implication
`define CDLL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CDLL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/cdll_pkg.sv
// ----------------------------------------------------------------------------
// cdll_pkg
// Shared types and constants for the circular doubly linked list block.
// ----------------------------------------------------------------------------
`default_nettype none

package cdll_pkg;

  localparam int CMD_W    = 3;
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam int DEF_MAX_ENTRIES = 64;
  localparam int DEF_DATA_BITS   = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_READ_AT   = 3'd6,
    CMD_NONE      = 3'd7
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_BADPOS = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_WALK,
    OP_INSERT,
    OP_DELETE
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_APPLY
  } state_t;

  typedef enum logic [1:0] {
    ACT_INSERT,
    ACT_DELETE,
    ACT_READ
  } act_t;

  typedef struct packed {
    logic                valid;
    status_t             status;
    logic [VALUE_W-1:0]  read_value;
    logic [COUNT_W-1:0]  count;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/cdll_cell.sv
// ----------------------------------------------------------------------------
// cdll_cell
// One list slot: stored word, position mask bit and a tap stage that shifts
// towards slot 0 during a walk.
// ----------------------------------------------------------------------------
`default_nettype none

module cdll_cell import cdll_pkg::*; #(
  parameter int DATA_BITS = DEF_DATA_BITS
) (
  input  wire logic                 clk,
  input  wire cell_op_t             op,
  input  wire logic [DATA_BITS-1:0] new_value,
  input  wire logic [DATA_BITS-1:0] left_val,
  input  wire logic                 left_sel,
  input  wire logic [DATA_BITS-1:0] right_val,
  input  wire logic [DATA_BITS-1:0] right_tap,
  output logic      [DATA_BITS-1:0] val_out,
  output logic                      sel_out,
  output logic      [DATA_BITS-1:0] tap_out
);

  logic [DATA_BITS-1:0] val_r;
  logic                 sel_r;
  logic [DATA_BITS-1:0] tap_r;

  always_ff @(posedge clk) begin
    unique case (op)
      OP_HOLD: begin
      end
      OP_LOAD: begin
        tap_r <= val_r;
        sel_r <= 1'b1;
      end
      OP_WALK: begin
        tap_r <= right_tap;
        sel_r <= left_sel;
      end
      OP_INSERT: begin
        priority if (left_sel) begin
          val_r <= left_val;
        end else if (sel_r) begin
          val_r <= new_value;
        end else begin
        end
      end
      OP_DELETE: begin
        if (sel_r) begin
          val_r <= right_val;
        end
      end
      default: begin
      end
    endcase
  end

  assign val_out = val_r;
  assign sel_out = sel_r;
  assign tap_out = tap_r;

endmodule

`default_nettype wire

>>> hw/rtl/cdll_ctrl.sv
// ----------------------------------------------------------------------------
// cdll_ctrl
// Command decode, entry count, walk sequencer and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cdll_ctrl import cdll_pkg::*; #(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int DATA_BITS   = DEF_DATA_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [CMD_W-1:0]     in_command,
  input  wire logic [POS_W-1:0]     in_position,
  input  wire logic [VALUE_W-1:0]   in_value,
  input  wire logic [DATA_BITS-1:0] tap_head,
  output logic                      busy,
  output cell_op_t                  cell_op,
  output logic      [DATA_BITS-1:0] new_value,
  output result_t                   res
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_ENTRIES);

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     walk_r;
  act_t                 act_r;
  logic [DATA_BITS-1:0] val_r;
  logic [CNT_W-1:0]     count_r;
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [VALUE_W-1:0]   out_rv_r;
  logic [COUNT_W-1:0]   out_count_r;

  logic                 accept;
  logic                 dec_go;
  status_t              dec_status;
  act_t                 dec_act;
  logic [CMP_W-1:0]     dec_k;
  logic [CMP_W-1:0]     pos_w;
  logic [CMP_W-1:0]     cnt_w;
  logic                 is_full;
  logic                 is_empty;
  logic                 ins_ok;
  logic                 pos_ok;
  logic [CNT_W-1:0]     count_upd;

  assign accept = start && (state_r == S_IDLE);

  always_comb begin
    pos_w      = CMP_W'(in_position);
    cnt_w      = CMP_W'(count_r);
    is_full    = (count_r == FULL_CNT);
    is_empty   = (count_r == '0);
    ins_ok     = (pos_w != '0) && (pos_w <= cnt_w + CMP_W'(1));
    pos_ok     = (pos_w != '0) && (pos_w <= cnt_w);
    dec_go     = 1'b0;
    dec_status = STAT_OK;
    dec_act    = ACT_READ;
    dec_k      = '0;
    unique case (cmd_t'(in_command))
      CMD_INS_FRONT: begin
        dec_act = ACT_INSERT;
        if (is_full) dec_status = STAT_FULL;
        else         dec_go     = 1'b1;
      end
      CMD_INS_BACK: begin
        dec_act = ACT_INSERT;
        dec_k   = cnt_w;
        if (is_full) dec_status = STAT_FULL;
        else         dec_go     = 1'b1;
      end
      CMD_INS_AT: begin
        dec_act = ACT_INSERT;
        dec_k   = pos_w - CMP_W'(1);
        priority if (is_full) begin
          dec_status = STAT_FULL;
        end else if (ins_ok) begin
          dec_go = 1'b1;
        end else begin
          dec_status = STAT_BADPOS;
        end
      end
      CMD_DEL_FRONT: begin
        dec_act = ACT_DELETE;
        if (is_empty) dec_status = STAT_EMPTY;
        else          dec_go     = 1'b1;
      end
      CMD_DEL_BACK: begin
        dec_act = ACT_DELETE;
        dec_k   = cnt_w - CMP_W'(1);
        if (is_empty) dec_status = STAT_EMPTY;
        else          dec_go     = 1'b1;
      end
      CMD_DEL_AT, CMD_READ_AT: begin
        dec_act = (cmd_t'(in_command) == CMD_DEL_AT) ? ACT_DELETE : ACT_READ;
        dec_k   = pos_w - CMP_W'(1);
        priority if (is_empty) begin
          dec_status = STAT_EMPTY;
        end else if (pos_ok) begin
          dec_go = 1'b1;
        end else begin
          dec_status = STAT_BADPOS;
        end
      end
      CMD_NONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    unique case (act_r)
      ACT_INSERT: count_upd = count_r + CNT_W'(1);
      ACT_DELETE: count_upd = count_r - CNT_W'(1);
      default:    count_upd = count_r;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && dec_go) begin
          state_nxt = (dec_k == '0) ? S_APPLY : S_WALK;
        end
      end
      S_WALK: begin
        if (walk_r == IDX_W'(1)) state_nxt = S_APPLY;
      end
      S_APPLY: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy    = (state_r != S_IDLE);
    cell_op = OP_HOLD;
    unique case (state_r)
      S_IDLE: begin
        if (accept && dec_go) cell_op = OP_LOAD;
      end
      S_WALK: cell_op = OP_WALK;
      S_APPLY: begin
        unique case (act_r)
          ACT_INSERT: cell_op = OP_INSERT;
          ACT_DELETE: cell_op = OP_DELETE;
          default:    cell_op = OP_HOLD;
        endcase
      end
      default: cell_op = OP_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (accept && !dec_go) || (state_r == S_APPLY);
      if (state_r == S_APPLY) count_r <= count_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      walk_r <= dec_k[IDX_W-1:0];
      act_r  <= dec_act;
      val_r  <= DATA_BITS'(in_value);
    end else if (state_r == S_WALK) begin
      walk_r <= walk_r - IDX_W'(1);
    end
    if (accept && !dec_go) begin
      out_status_r <= dec_status;
      out_rv_r     <= '0;
      out_count_r  <= COUNT_W'(count_r);
    end else if (state_r == S_APPLY) begin
      out_status_r <= STAT_OK;
      out_rv_r     <= (act_r == ACT_INSERT) ? '0 : VALUE_W'(tap_head);
      out_count_r  <= COUNT_W'(count_upd);
    end
  end

  assign new_value      = val_r;
  assign res.valid      = out_valid_r;
  assign res.status     = out_status_r;
  assign res.read_value = out_rv_r;
  assign res.count      = out_count_r;

endmodule

`default_nettype wire

>>> hw/rtl/circular_doubly_linked_list.sv
// ----------------------------------------------------------------------------
// circular_doubly_linked_list
// Bounded list of signed words with front, back and positional commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. The list is kept in
// order in a row of MAX_ENTRIES slot cells. A command that succeeds on
// 0-based list index k is loaded into the cell row at acceptance and then
// holds busy through k shift steps of the tap row towards slot 0 (one slot
// per cycle) and then the update, which for an insert or delete shifts the
// slots from index k on by one place. Front operations need no shift step;
// a delete at the back walks to index count-1 and an insert at the back to
// index count; a command at position p walks to index p-1. The result strobe
// out_valid is high for exactly one cycle, the first cycle with busy low
// again; a command that fails its check, and command code 7, answers in the
// cycle after acceptance without raising busy, so such commands may follow
// one another every cycle. The receiver cannot hold a result off: it must
// take out_status, out_read_value and out_count in the strobe cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_doubly_linked_list import cdll_pkg::*; #(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int DATA_BITS   = DEF_DATA_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [CMD_W-1:0]    in_command,
  input  wire logic [POS_W-1:0]    in_position,
  input  wire logic [VALUE_W-1:0]  in_value,
  output logic                     out_valid,
  output logic      [STATUS_W-1:0] out_status,
  output logic      [VALUE_W-1:0]  out_read_value,
  output logic      [COUNT_W-1:0]  out_count
);

  cell_op_t             cell_op;
  logic [DATA_BITS-1:0] new_value;
  result_t              res;

  logic [DATA_BITS-1:0] val_pad [MAX_ENTRIES+2];
  logic                 sel_pad [MAX_ENTRIES+1];
  logic [DATA_BITS-1:0] tap_pad [MAX_ENTRIES+1];

  assign val_pad[0]             = '0;
  assign val_pad[MAX_ENTRIES+1] = '0;
  assign sel_pad[0]             = 1'b0;
  assign tap_pad[MAX_ENTRIES]   = '0;

  cdll_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .DATA_BITS   (DATA_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_command  (in_command),
    .in_position (in_position),
    .in_value    (in_value),
    .tap_head    (tap_pad[0]),
    .busy        (busy),
    .cell_op     (cell_op),
    .new_value   (new_value),
    .res         (res)
  );

  for (genvar j = 0; j < MAX_ENTRIES; j++) begin : g_cell
    cdll_cell #(
      .DATA_BITS (DATA_BITS)
    ) u_cell (
      .clk       (clk),
      .op        (cell_op),
      .new_value (new_value),
      .left_val  (val_pad[j]),
      .left_sel  (sel_pad[j]),
      .right_val (val_pad[j+2]),
      .right_tap (tap_pad[j+1]),
      .val_out   (val_pad[j+1]),
      .sel_out   (sel_pad[j+1]),
      .tap_out   (tap_pad[j])
    );
  end

  assign out_valid      = res.valid;
  assign out_status     = res.status;
  assign out_read_value = res.read_value;
  assign out_count      = res.count;

endmodule

`default_nettype wire

>>> hw/rtl/cdll_checker.sv
// ----------------------------------------------------------------------------
// cdll_checker
// Port-level checks on the command and result handshake and on failed results, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "circular_doubly_linked_list_assert.svh"

module cdll_checker import cdll_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                out_valid,
  input wire logic [STATUS_W-1:0] out_status,
  input wire logic [VALUE_W-1:0]  out_read_value,
  input wire logic [COUNT_W-1:0]  out_count
);

  `CDLL_ASSERT_NEXT(a_accept_answered, start && !busy, out_valid || busy, "transaction lost")
  `CDLL_ASSERT_SAME(a_result_idle, out_valid, !busy, "result while busy")
  `CDLL_ASSERT_SAME(a_result_caused, out_valid, $past(start && !busy) || $past(busy), "spurious result")
  `CDLL_ASSERT_SAME(a_empty_count, out_valid && out_status == STAT_EMPTY, out_count == '0, "empty with entries")
  `CDLL_ASSERT_SAME(a_fail_value, out_valid && out_status != STAT_OK, out_read_value == '0, "value on failure")

endmodule

bind circular_doubly_linked_list cdll_checker u_cdll_checker (.*);

`default_nettype wire

>>> sim/tb_circular_doubly_linked_list.sv
// ----------------------------------------------------------------------------
// tb_circular_doubly_linked_list
// Self-checking bench for the circular doubly linked list block: a shadow
// queue mirrors the list, predicts status, value and count for each accepted
// command, and checks every strobed response in order.
// ----------------------------------------------------------------------------
module tb_circular_doubly_linked_list;
  timeunit 1ns;
  timeprecision 1ps;

  import cdll_pkg::*;

  localparam int DEPTH       = DEF_MAX_ENTRIES;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 630;

  typedef struct {
    status_t            status;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } response_t;

  class list_shadow;
    logic [VALUE_W-1:0] entries[$];
    response_t          due_responses[$];
    int                 failures = 0;

    function void note_command(cmd_t cmd, logic [POS_W-1:0] pos, logic [VALUE_W-1:0] val);
      response_t r;
      int        n;
      int        p;
      n = entries.size();
      p = int'(pos);
      r.status = STAT_OK;
      r.value  = '0;
      case (cmd)
        CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
          if (n >= DEPTH) begin
            r.status = STAT_FULL;
          end else if (cmd == CMD_INS_FRONT || (cmd == CMD_INS_AT && p == 1)) begin
            entries.push_front(val);
          end else if (cmd == CMD_INS_BACK || (cmd == CMD_INS_AT && p == n + 1)) begin
            entries.push_back(val);
          end else if (p >= 2 && p <= n) begin
            entries.insert(p - 1, val);
          end else begin
            r.status = STAT_BADPOS;
          end
        end
        CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT, CMD_READ_AT: begin
          if (n == 0) begin
            r.status = STAT_EMPTY;
          end else if (cmd == CMD_DEL_FRONT) begin
            r.value = entries.pop_front();
          end else if (cmd == CMD_DEL_BACK) begin
            r.value = entries.pop_back();
          end else if (p < 1 || p > n) begin
            r.status = STAT_BADPOS;
          end else if (cmd == CMD_DEL_AT) begin
            r.value = entries[p - 1];
            entries.delete(p - 1);
          end else begin
            r.value = entries[p - 1];
          end
        end
        default: ;
      endcase
      r.count = COUNT_W'(entries.size());
      due_responses.push_back(r);
    endfunction

    function void check_response(logic [STATUS_W-1:0] status, logic [VALUE_W-1:0] value,
                                 logic [COUNT_W-1:0] count);
      response_t exp_r;
      if (due_responses.size() == 0) begin
        $display("%0t: response with no transaction outstanding", $time);
        failures++;
        return;
      end
      exp_r = due_responses.pop_front();
      if (status !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status);
        failures++;
      end
      if (value !== exp_r.value) begin
        $display("%0t: read_value expected %0d actual %0d", $time,
                 $signed(exp_r.value), $signed(value));
        failures++;
      end
      if (count !== exp_r.count) begin
        $display("%0t: count expected %0d actual %0d", $time, exp_r.count, count);
        failures++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [CMD_W-1:0]    in_command = '0;
  logic [POS_W-1:0]    in_position = '0;
  logic [VALUE_W-1:0]  in_value = '0;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [VALUE_W-1:0]  out_read_value;
  logic [COUNT_W-1:0]  out_count;

  list_shadow shadow = new();
  int         cycles = 0;
  bit         growing = 1'b1;

  circular_doubly_linked_list u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_count      (out_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[circular_doubly_linked_list] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      shadow.check_response(out_status, out_read_value, out_count);
    end
  end

  task automatic send_command(cmd_t cmd, logic [POS_W-1:0] pos, logic [VALUE_W-1:0] val,
                              int idle_pct);
    start       <= 1'b1;
    in_command  <= cmd;
    in_position <= pos;
    in_value    <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    shadow.note_command(cmd, pos, val);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (shadow.due_responses.size() != 0) @(posedge clk);
  endtask

  task automatic send_random(int idle_pct);
    cmd_t               cmd;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] val;
    int                 n;
    int                 r;
    n = shadow.entries.size();
    r = $urandom_range(99);
    if (r >= 97) begin
      cmd = CMD_NONE;
    end else if (r < (growing ? 60 : 20)) begin
      cmd = cmd_t'($urandom_range(CMD_INS_FRONT, CMD_INS_AT));
    end else if (r < (growing ? 80 : 35)) begin
      cmd = CMD_READ_AT;
    end else begin
      cmd = cmd_t'($urandom_range(CMD_DEL_FRONT, CMD_DEL_AT));
    end
    // positions: mostly legal, weighted to the ends; some anywhere in the field
    if ($urandom_range(99) < 20) begin
      pos = POS_W'($urandom_range(0, 127));
    end else if (cmd == CMD_INS_AT || cmd == CMD_INS_FRONT || cmd == CMD_INS_BACK) begin
      case ($urandom_range(3))
        0:       pos = 1;
        1:       pos = POS_W'(n + 1);
        default: pos = POS_W'($urandom_range(1, n + 1));
      endcase
    end else if (n > 0) begin
      case ($urandom_range(3))
        0:       pos = 1;
        1:       pos = POS_W'(n);
        default: pos = POS_W'($urandom_range(1, n));
      endcase
    end else begin
      pos = POS_W'($urandom_range(0, 127));
    end
    case ($urandom_range(15))
      0:       val = 32'h8000_0000;
      1:       val = 32'h7fff_ffff;
      2:       val = 32'hffff_ffff;
      3:       val = 32'h0000_0000;
      default: val = $urandom;
    endcase
    send_command(cmd, pos, val, idle_pct);
    n = shadow.entries.size();
    if (n == DEPTH && $urandom_range(7) == 0) growing = 1'b0;
    if (n == 0 && $urandom_range(3) == 0) growing = 1'b1;
    if ($urandom_range(199) == 0) wait_for_results();
  endtask

  task automatic run_directed();
    send_command(CMD_DEL_FRONT, 1, 32'h0, 26);
    send_command(CMD_DEL_BACK, 1, 32'h0, 26);
    send_command(CMD_DEL_AT, 1, 32'h0, 26);
    send_command(CMD_READ_AT, 1, 32'h0, 26);
    send_command(CMD_INS_AT, 2, 32'h1234_5678, 26);
    send_command(CMD_INS_AT, 0, 32'h1234_5678, 26);
    send_command(CMD_INS_AT, 1, 32'h7fff_ffff, 26);
    send_command(CMD_INS_BACK, 1, 32'h8000_0000, 26);
    send_command(CMD_INS_AT, 3, 32'hffff_ffff, 26);
    send_command(CMD_INS_AT, 2, 32'h0000_0000, 26);
    send_command(CMD_INS_FRONT, 127, 32'h0000_0001, 26);
    send_command(CMD_READ_AT, 1, 32'h0, 26);
    send_command(CMD_READ_AT, 5, 32'h0, 26);
    send_command(CMD_READ_AT, 6, 32'h0, 26);
    send_command(CMD_READ_AT, 0, 32'h0, 26);
    send_command(CMD_READ_AT, 127, 32'hffff_ffff, 26);
    send_command(CMD_NONE, 127, 32'hffff_ffff, 26);
    send_command(CMD_INS_AT, 127, 32'h5555_aaaa, 26);
    send_command(CMD_DEL_AT, 1, 32'h0, 26);
    send_command(CMD_DEL_AT, 4, 32'h0, 26);
    send_command(CMD_DEL_AT, 2, 32'h0, 26);
    send_command(CMD_DEL_AT, 3, 32'h0, 26);
    send_command(CMD_DEL_BACK, 0, 32'h0, 26);
    send_command(CMD_DEL_FRONT, 0, 32'h0, 26);
    send_command(CMD_INS_FRONT, 0, 32'haaaa_5555, 26);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    wait_for_results();
    repeat (PHASE_ITEMS) send_random(26);
    wait_for_results();
    repeat (PHASE_ITEMS) send_random(72);
    wait_for_results();
    repeat (PHASE_ITEMS) send_random(0);
    wait_for_results();
    repeat (80) @(posedge clk);
    if (shadow.failures == 0 && shadow.due_responses.size() == 0) begin
      $display("[circular_doubly_linked_list] OK");
    end else begin
      $display("[circular_doubly_linked_list] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/cdll_pkg.sv
hw/rtl/cdll_cell.sv
hw/rtl/cdll_ctrl.sv
hw/rtl/circular_doubly_linked_list.sv
hw/rtl/cdll_checker.sv
sim/tb_circular_doubly_linked_list.sv
